// File: hdl/unf_pkg.sv
// ----------------------------------------------------------------------------
// unf_pkg
// Shared types and constants of the UDP-Notif segmenting framer: header
// sizes, status codes, register indexes and the command passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package unf_pkg;

  // Width of the message length field.
  localparam int LENGTH_BITS = 24;
  localparam int LEN_EXT_W   = LENGTH_BITS + 1;

  // Header sizes and segmentation limits.
  localparam int HDR_BASE    = 12;
  localparam int HDR_SEG     = 16;
  localparam int DEFAULT_MSS = 1400;
  localparam int SEG_NUM_W   = 15;
  localparam logic [SEG_NUM_W-1:0] SEG_LIMIT = {SEG_NUM_W{1'b1}};
  localparam int SEG_CAP_W   = 16 + SEG_NUM_W;
  localparam int CMP_W       = ((LENGTH_BITS > SEG_CAP_W) ? LENGTH_BITS : SEG_CAP_W) + 1;
  localparam int HDR_IDX_W   = $clog2(HDR_SEG + 1);

  // Header constants.
  localparam logic [7:0] VERSION_BITS = 8'h20;
  localparam logic [7:0] OPT_TYPE_SEG = 8'h01;
  localparam logic [7:0] OPT_LEN_SEG  = 8'h04;
  localparam logic [3:0] MEDIA_JSON   = 4'd1;
  localparam logic [3:0] MEDIA_XML    = 4'd2;

  // Payload encodings.
  localparam logic [1:0] ENC_XML  = 2'd1;
  localparam logic [1:0] ENC_CBOR = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLISHER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_EN    = 2'd2;

  // Command queue depth.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CBOR      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_SEG_SMALL = 3'd3,
    ST_SEG_LIMIT = 3'd4
  } status_e_t;

  typedef enum logic {
    CMD_STATUS = 1'b0,
    CMD_BYTE   = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    HDR_NONE  = 2'd0,
    HDR_SHORT = 2'd1,
    HDR_LONG  = 2'd2
  } hdr_kind_t;

  // Settings the front end needs.
  typedef struct packed {
    logic [15:0] max_seg;
    logic        seg_en;
  } cfg_t;

  // One unit of work for the back end: an optional header, then either a
  // payload byte or a status-only result.
  typedef struct packed {
    cmd_kind_t            kind;
    hdr_kind_t            hdr;
    status_e_t            status;
    logic [3:0]           media;
    logic [15:0]          dlen;
    logic [31:0]          msg_id;
    logic [SEG_NUM_W-1:0] seg_num;
    logic                 seg_last;
    logic [7:0]           data;
    logic                 data_last;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       valid;
    status_e_t  status;
    logic       run_last;
  } res_t;

endpackage

// File: hdl/unf_front.sv
// ----------------------------------------------------------------------------
// unf_front
// Classifies each accepted payload byte, keeps the message and segment
// bookkeeping and issues one command per byte that yields results.
// ----------------------------------------------------------------------------
module unf_front import unf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             payload_byte,
  input  logic                   message_start,
  input  logic [LENGTH_BITS-1:0] payload_length,
  input  logic [1:0]             encoding,
  input  cfg_t                   cfg,
  output logic                   cmd_push,
  output cmd_t                   cmd
);

  logic [31:0]            msg_cnt_r, msg_cnt_nxt;
  logic [31:0]            cur_msg_r, cur_msg_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [15:0]            chunk_r, chunk_nxt;
  logic [15:0]            seg_num_r, seg_num_nxt;
  logic                   drop_r, drop_nxt;
  logic [3:0]             media_r, media_nxt;

  logic [15:0] mss;
  logic [15:0] per;
  logic        fits;
  logic        seg_small;
  logic        too_many;

  // Effective segment size and the size checks made at message start.
  always_comb begin
    mss       = (cfg.max_seg == 16'd0) ? 16'(DEFAULT_MSS) : cfg.max_seg;
    per       = mss - 16'(HDR_SEG);
    seg_small = (mss <= 16'(HDR_SEG));
    fits      = (({1'b0, payload_length} + LEN_EXT_W'(HDR_BASE)) <= LEN_EXT_W'(mss));
    too_many  = (CMP_W'(payload_length) > CMP_W'({per, {SEG_NUM_W{1'b0}}}));
  end

  // Per-byte decision.
  always_comb begin
    logic [LENGTH_BITS-1:0] rem_v;
    logic [15:0]            chunk_v;
    logic                   do_byte;
    logic                   seg_go;
    logic [15:0]            seg_v;
    logic                   last_v;

    msg_cnt_nxt = msg_cnt_r;
    cur_msg_nxt = cur_msg_r;
    rem_nxt     = rem_r;
    chunk_nxt   = chunk_r;
    seg_num_nxt = seg_num_r;
    drop_nxt    = drop_r;
    media_nxt   = media_r;
    rem_v       = rem_r;
    chunk_v     = chunk_r;
    do_byte     = 1'b0;
    seg_go      = 1'b0;
    seg_v       = seg_num_r;
    last_v      = 1'b0;
    cmd_push    = 1'b0;
    cmd         = '0;
    cmd.kind    = CMD_STATUS;
    cmd.hdr     = HDR_NONE;
    cmd.status  = ST_OK;

    if (accept) begin
      if (message_start) begin
        if (payload_length != '0) begin
          if (encoding == ENC_CBOR) begin
            cmd_push   = 1'b1;
            cmd.status = ST_CBOR;
          end else begin
            media_nxt   = (encoding == ENC_XML) ? MEDIA_XML : MEDIA_JSON;
            cur_msg_nxt = msg_cnt_r;
            msg_cnt_nxt = msg_cnt_r + 32'd1;
            rem_v       = payload_length;
            drop_nxt    = 1'b0;
            if (fits) begin
              chunk_v  = payload_length[15:0];
              do_byte  = 1'b1;
              cmd.hdr  = HDR_SHORT;
              cmd.dlen = 16'(HDR_BASE) + payload_length[15:0];
            end else if (!cfg.seg_en) begin
              cmd_push   = 1'b1;
              cmd.status = ST_TOO_LARGE;
            end else if (seg_small) begin
              cmd_push   = 1'b1;
              cmd.status = ST_SEG_SMALL;
            end else if (too_many) begin
              cmd_push   = 1'b1;
              cmd.status = ST_SEG_LIMIT;
            end else begin
              seg_go = 1'b1;
              seg_v  = 16'd0;
            end
          end
          // A rejected message swallows the rest of its bytes.
          if (cmd_push) begin
            rem_nxt   = payload_length - 1'b1;
            drop_nxt  = (payload_length != LENGTH_BITS'(1));
            chunk_nxt = '0;
          end
        end
      end else if (rem_r != '0) begin
        if (drop_r) begin
          rem_nxt  = rem_r - 1'b1;
          drop_nxt = (rem_r != LENGTH_BITS'(1));
        end else if (chunk_r == 16'd0) begin
          // Next segment: the settings may have changed since the last one.
          if (seg_small) begin
            cmd_push   = 1'b1;
            cmd.status = ST_SEG_SMALL;
          end else if (seg_num_r[15]) begin
            cmd_push   = 1'b1;
            cmd.status = ST_SEG_LIMIT;
          end else begin
            seg_go = 1'b1;
          end
          if (cmd_push) begin
            rem_nxt   = rem_r - 1'b1;
            drop_nxt  = (rem_r != LENGTH_BITS'(1));
            chunk_nxt = '0;
          end
        end else begin
          do_byte = 1'b1;
        end
      end
    end

    // Segment header: this segment carries what is left, up to one chunk.
    if (seg_go) begin
      last_v       = (rem_v <= LENGTH_BITS'(per));
      chunk_v      = last_v ? rem_v[15:0] : per;
      seg_num_nxt  = seg_v + 16'd1;
      cmd.hdr      = HDR_LONG;
      cmd.dlen     = 16'(HDR_SEG) + chunk_v;
      cmd.seg_num  = seg_v[SEG_NUM_W-1:0];
      cmd.seg_last = last_v;
      do_byte      = 1'b1;
    end

    // Payload byte.
    if (do_byte) begin
      chunk_v       = chunk_v - 16'd1;
      rem_v         = rem_v - 1'b1;
      cmd_push      = 1'b1;
      cmd.kind      = CMD_BYTE;
      cmd.media     = media_nxt;
      cmd.msg_id    = cur_msg_nxt;
      cmd.data      = payload_byte;
      cmd.data_last = (chunk_v == 16'd0);
      rem_nxt       = rem_v;
      chunk_nxt     = (rem_v == '0) ? 16'd0 : chunk_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_cnt_r <= 32'd1;
      cur_msg_r <= '0;
      rem_r     <= '0;
      chunk_r   <= '0;
      seg_num_r <= '0;
      drop_r    <= 1'b0;
      media_r   <= '0;
    end else begin
      msg_cnt_r <= msg_cnt_nxt;
      cur_msg_r <= cur_msg_nxt;
      rem_r     <= rem_nxt;
      chunk_r   <= chunk_nxt;
      seg_num_r <= seg_num_nxt;
      drop_r    <= drop_nxt;
      media_r   <= media_nxt;
    end
  end

  // A message being swallowed always has bytes left.
  a_drop_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (rem_r != '0))
    else $error("dropping with no bytes remaining");

  // The current chunk never runs past the end of the message.
  a_chunk_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (LENGTH_BITS'(chunk_r) <= rem_r))
    else $error("chunk longer than the rest of the message");

endmodule

// File: hdl/unf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// unf_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module unf_cmd_fifo import unf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (FIFO_AW+1)'(push && !full) - (FIFO_AW+1)'(pop && !empty);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("command queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("back end popped an empty command queue");

endmodule

// File: hdl/unf_back.sv
// ----------------------------------------------------------------------------
// unf_back
// Expands each command into header beats and a payload or status beat and
// holds the oldest beat in the output register.
// ----------------------------------------------------------------------------
module unf_back import unf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic        cmd_empty,
  output logic        cmd_pop,
  input  logic [31:0] pub_id,
  output res_t        res,
  output logic        res_empty,
  input  logic        res_pop
);

  logic [HDR_IDX_W-1:0] idx_r, idx_nxt;
  res_t                 out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [HDR_IDX_W-1:0] hlen;
  logic                 advance;
  logic                 final_beat;
  logic [15:0]          seg_word;
  logic [7:0]           hdr_byte;

  assign res       = out_r;
  assign res_empty = !out_valid_r;
  assign advance   = !out_valid_r || res_pop;
  assign seg_word  = {cmd.seg_num, cmd.seg_last};

  always_comb begin
    unique case (cmd.hdr)
      HDR_SHORT: hlen = HDR_IDX_W'(HDR_BASE);
      HDR_LONG:  hlen = HDR_IDX_W'(HDR_SEG);
      default:   hlen = '0;
    endcase
  end

  assign final_beat = (cmd.kind == CMD_STATUS) || (idx_r == hlen);

  // Header byte at the current position.
  always_comb begin
    unique case (idx_r)
      5'd0:    hdr_byte = VERSION_BITS | {4'd0, cmd.media};
      5'd1:    hdr_byte = 8'(hlen);
      5'd2:    hdr_byte = cmd.dlen[15:8];
      5'd3:    hdr_byte = cmd.dlen[7:0];
      5'd4:    hdr_byte = pub_id[31:24];
      5'd5:    hdr_byte = pub_id[23:16];
      5'd6:    hdr_byte = pub_id[15:8];
      5'd7:    hdr_byte = pub_id[7:0];
      5'd8:    hdr_byte = cmd.msg_id[31:24];
      5'd9:    hdr_byte = cmd.msg_id[23:16];
      5'd10:   hdr_byte = cmd.msg_id[15:8];
      5'd11:   hdr_byte = cmd.msg_id[7:0];
      5'd12:   hdr_byte = OPT_TYPE_SEG;
      5'd13:   hdr_byte = OPT_LEN_SEG;
      5'd14:   hdr_byte = seg_word[15:8];
      5'd15:   hdr_byte = seg_word[7:0];
      default: hdr_byte = 8'd0;
    endcase
  end

  // Beat sequencing.
  always_comb begin
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    cmd_pop       = 1'b0;
    if (advance) begin
      out_valid_nxt = !cmd_empty;
      if (!cmd_empty) begin
        out_nxt = '0;
        out_nxt.status = ST_OK;
        if (cmd.kind == CMD_STATUS) begin
          out_nxt.status   = cmd.status;
          out_nxt.run_last = 1'b1;
        end else if (final_beat) begin
          out_nxt.data     = cmd.data;
          out_nxt.last     = cmd.data_last;
          out_nxt.valid    = 1'b1;
          out_nxt.run_last = 1'b1;
        end else begin
          out_nxt.data  = hdr_byte;
          out_nxt.first = (idx_r == '0);
          out_nxt.valid = 1'b1;
        end
        if (final_beat) begin
          cmd_pop = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // A status-only beat always carries an error code and ends its run.
  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.valid) |-> (out_r.status != ST_OK && out_r.run_last))
    else $error("status beat without error code");

endmodule

// File: hdl/udp_notif_segmenting_framer.sv
// ----------------------------------------------------------------------------
// udp_notif_segmenting_framer
// Frames encoded notification payload bytes into UDP-Notif datagrams.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one payload byte per beat; in_message_start marks the
//   first byte of a message and carries its length and encoding. A beat is
//   taken when in_push is high and in_full is low.
//   Result channel: out_* holds the oldest result while out_empty is low;
//   out_pop takes it. Results are header beats, payload beats or a single
//   status-only beat for a rejected message.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 publisher id, 1 max segment size, 2 segmentation enable).
//   Path: a taken payload byte is written into the command queue, then
//   into the output register. A byte that opens a datagram first yields
//   12 header beats (16 for a segment) before its own payload beat.
//   Throughput: one result beat per cycle while the receiver pops, set by
//   the back-end sequencer; a four-entry command queue lets the input run
//   on during header beats and raises in_full once it fills.
//   Reset: control registers clear to zero, the message id counter starts at one.
//   When the receiver stalls, the output register holds its beat, the queue
//   fills and in_full back-pressures the sender.
// ----------------------------------------------------------------------------
module udp_notif_segmenting_framer import unf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [7:0]             in_payload_byte,
  input  logic                   in_message_start,
  input  logic [LENGTH_BITS-1:0] in_payload_length,
  input  logic [1:0]             in_encoding,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [7:0]             out_byte,
  output logic                   out_datagram_first,
  output logic                   out_datagram_last,
  output logic                   out_byte_valid,
  output logic [2:0]             out_status,
  output logic                   out_run_last,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [31:0] publisher_r;
  logic [15:0] max_seg_r;
  logic        seg_en_r;

  cfg_t cfg;
  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  logic q_full;
  logic q_pop;
  cmd_t q_head;
  logic q_empty;
  res_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      publisher_r <= '0;
      max_seg_r   <= '0;
      seg_en_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PUBLISHER: publisher_r <= cfg_wdata[31:0];
        CFG_MAX_SEG:   max_seg_r   <= cfg_wdata[15:0];
        CFG_SEG_EN:    seg_en_r    <= cfg_wdata[0];
        default:       ;
      endcase
    end
  end

  assign cfg.max_seg = max_seg_r;
  assign cfg.seg_en  = seg_en_r;
  assign in_full     = q_full;
  assign accept      = in_push && !q_full;

  unf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .payload_byte   (in_payload_byte),
    .message_start  (in_message_start),
    .payload_length (in_payload_length),
    .encoding       (in_encoding),
    .cfg            (cfg),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  unf_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  unf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_head),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .pub_id    (publisher_r),
    .res       (res),
    .res_empty (out_empty),
    .res_pop   (out_pop)
  );

  assign out_byte           = res.data;
  assign out_datagram_first = res.first;
  assign out_datagram_last  = res.last;
  assign out_byte_valid     = res.valid;
  assign out_status         = res.status;
  assign out_run_last       = res.run_last;

endmodule

// File: tb/unf_checker.sv
// ----------------------------------------------------------------------------
// unf_checker
// Watches the input, result and configuration ports of the UDP-Notif
// segmenting framer. It keeps its own copy of the framer state, works out
// the header, payload and status beats that each accepted input beat must
// produce, and compares every popped result beat with the oldest one owed.
// ----------------------------------------------------------------------------
module unf_checker import unf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic                   in_full,
  input  logic [7:0]             in_payload_byte,
  input  logic                   in_message_start,
  input  logic [LENGTH_BITS-1:0] in_payload_length,
  input  logic [1:0]             in_encoding,
  input  logic                   out_empty,
  input  logic                   out_pop,
  input  logic [7:0]             out_byte,
  input  logic                   out_datagram_first,
  input  logic                   out_datagram_last,
  input  logic                   out_byte_valid,
  input  logic [2:0]             out_status,
  input  logic                   out_run_last,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     beats_due,
  output int                     mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies.
  logic [31:0]            pub_reg;
  logic [15:0]            mss_reg;
  logic                   seg_en_reg;

  // Framer state.
  logic [31:0]            msg_ctr;
  logic [31:0]            cur_id;
  logic [LENGTH_BITS-1:0] bytes_left;
  logic [15:0]            chunk_left;
  logic [15:0]            seg_idx;
  logic                   drop_mode;
  logic [3:0]             media;

  // Result beats still owed by the framer, oldest first.
  res_t                   owed_beats [$];
  res_t                   want;

  task automatic add_beat(input logic [7:0] data, input logic first, input logic last,
                          input logic valid, input status_e_t status,
                          input logic run_last);
    res_t r;
    r.data     = data;
    r.first    = first;
    r.last     = last;
    r.valid    = valid;
    r.status   = status;
    r.run_last = run_last;
    owed_beats.push_back(r);
  endtask

  // Header beats: the 12-byte base header, plus the segmentation option
  // when the header is 16 bytes long.
  task automatic add_header(input logic [7:0] hlen, input logic [15:0] dlen,
                            input logic [15:0] segnum, input logic lastseg);
    logic [7:0]  hb [HDR_SEG];
    logic [15:0] seg_word;
    int          k;
    seg_word = {segnum[SEG_NUM_W-1:0], lastseg};
    hb[0] = VERSION_BITS | {4'd0, media};
    hb[1] = hlen;
    hb[2] = dlen[15:8];
    hb[3] = dlen[7:0];
    for (k = 0; k < 4; k++) begin
      hb[4 + k] = pub_reg[31 - 8 * k -: 8];
      hb[8 + k] = cur_id[31 - 8 * k -: 8];
    end
    hb[12] = OPT_TYPE_SEG;
    hb[13] = OPT_LEN_SEG;
    hb[14] = seg_word[15:8];
    hb[15] = seg_word[7:0];
    for (k = 0; k < hlen; k++)
      add_beat(hb[k], k == 0, 1'b0, 1'b1, ST_OK, 1'b0);
  endtask

  // A refused message gives one status-only beat; the rest of it is swallowed.
  task automatic refuse(input status_e_t status, input logic [LENGTH_BITS-1:0] rest);
    bytes_left = rest;
    drop_mode  = (rest != 0);
    chunk_left = '0;
    add_beat(8'd0, 1'b0, 1'b0, 1'b0, status, 1'b1);
  endtask

  task automatic open_segment(input int unsigned mss);
    int unsigned per;
    logic        lastseg;
    per        = mss - HDR_SEG;
    lastseg    = (bytes_left <= per);
    chunk_left = lastseg ? bytes_left[15:0] : per[15:0];
    add_header(8'(HDR_SEG), 16'(HDR_SEG) + chunk_left, seg_idx, lastseg);
    seg_idx = seg_idx + 16'd1;
  endtask

  // Works out every result beat that one accepted input beat causes.
  task automatic frame_byte(input logic [7:0] pb, input logic st,
                            input logic [LENGTH_BITS-1:0] len, input logic [1:0] enc);
    int unsigned mss;
    logic        emit;
    mss  = (mss_reg == 16'd0) ? DEFAULT_MSS : mss_reg;
    emit = 1'b0;
    if (st) begin
      // A start with zero length is ignored altogether.
      if (len != 0) begin
        if (enc == ENC_CBOR) begin
          refuse(ST_CBOR, len - 1'b1);
        end else begin
          // Every accepted encoding takes a message id, even if refused later.
          media      = (enc == ENC_XML) ? MEDIA_XML : MEDIA_JSON;
          cur_id     = msg_ctr;
          msg_ctr    = msg_ctr + 32'd1;
          bytes_left = len;
          drop_mode  = 1'b0;
          if (longint'(HDR_BASE) + len <= mss) begin
            chunk_left = len[15:0];
            add_header(8'(HDR_BASE), 16'(HDR_BASE) + len[15:0], 16'd0, 1'b0);
            emit = 1'b1;
          end else if (!seg_en_reg) begin
            refuse(ST_TOO_LARGE, len - 1'b1);
          end else if (mss <= HDR_SEG) begin
            refuse(ST_SEG_SMALL, len - 1'b1);
          end else if (longint'(len) >
                       (longint'(SEG_LIMIT) + 1) * longint'(mss - HDR_SEG)) begin
            refuse(ST_SEG_LIMIT, len - 1'b1);
          end else begin
            seg_idx = '0;
            open_segment(mss);
            emit = 1'b1;
          end
        end
      end
    end else if (bytes_left != 0) begin
      if (drop_mode) begin
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) drop_mode = 1'b0;
      end else if (chunk_left == 0) begin
        // Next segment: the current registers decide its size and fate.
        if (mss <= HDR_SEG) begin
          refuse(ST_SEG_SMALL, bytes_left - 1'b1);
        end else if (seg_idx > SEG_LIMIT) begin
          refuse(ST_SEG_LIMIT, bytes_left - 1'b1);
        end else begin
          open_segment(mss);
          emit = 1'b1;
        end
      end else begin
        emit = 1'b1;
      end
    end
    if (emit) begin
      chunk_left = chunk_left - 16'd1;
      bytes_left = bytes_left - 1'b1;
      add_beat(pb, 1'b0, chunk_left == 0, 1'b1, ST_OK, 1'b1);
      if (bytes_left == 0) chunk_left = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Compare popped beats, follow register writes and predict accepted beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      pub_reg    = '0;
      mss_reg    = '0;
      seg_en_reg = 1'b0;
      msg_ctr    = 32'd1;
      cur_id     = '0;
      bytes_left = '0;
      chunk_left = '0;
      seg_idx    = '0;
      drop_mode  = 1'b0;
      media      = '0;
      owed_beats.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (owed_beats.size() == 0) begin
          $error("result beat with nothing owed: byte 0x%0h, status %0d",
                 out_byte, out_status);
          mismatches++;
        end else begin
          want = owed_beats.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_datagram_first", 8'(want.first), 8'(out_datagram_first));
          check_field("out_datagram_last", 8'(want.last), 8'(out_datagram_last));
          check_field("out_byte_valid", 8'(want.valid), 8'(out_byte_valid));
          check_field("out_status", 8'(want.status), 8'(out_status));
          check_field("out_run_last", 8'(want.run_last), 8'(out_run_last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PUBLISHER: pub_reg = cfg_wdata;
          CFG_MAX_SEG:   mss_reg = cfg_wdata[15:0];
          CFG_SEG_EN:    seg_en_reg = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_push && !in_full)
        frame_byte(in_payload_byte, in_message_start, in_payload_length, in_encoding);
    end
    beats_due <= owed_beats.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the UDP-Notif segmenting framer: a directed opening over the
// field extremes and every refusal case, randomized message traffic under
// several register settings, and a short segmented run at full rate on both
// sides. A separate checker predicts and compares the result beats.
// ----------------------------------------------------------------------------
module tb_top;
  import unf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ENC_UNSET      = 2'd0;
  localparam logic [1:0] ENC_JSON       = 2'd2;
  localparam int         QUIET_CYCLES   = 40;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_push;
  logic                   in_full;
  logic [7:0]             in_payload_byte;
  logic                   in_message_start;
  logic [LENGTH_BITS-1:0] in_payload_length;
  logic [1:0]             in_encoding;
  logic                   out_empty;
  logic                   out_pop = 1'b0;
  logic [7:0]             out_byte;
  logic                   out_datagram_first;
  logic                   out_datagram_last;
  logic                   out_byte_valid;
  logic [2:0]             out_status;
  logic                   out_run_last;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int                     beats_due;
  int                     mismatches;
  int                     idle_cycles;
  int                     burst_left = 0;
  bit                     tx_steady = 1'b0;
  bit                     rx_steady = 1'b0;
  logic [4:0]             rx_phase = '0;
  logic [15:0]            rx_pattern = '1;

  udp_notif_segmenting_framer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_payload_byte    (in_payload_byte),
    .in_message_start   (in_message_start),
    .in_payload_length  (in_payload_length),
    .in_encoding        (in_encoding),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_byte           (out_byte),
    .out_datagram_first (out_datagram_first),
    .out_datagram_last  (out_datagram_last),
    .out_byte_valid     (out_byte_valid),
    .out_status         (out_status),
    .out_run_last       (out_run_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  unf_checker u_frame_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_payload_byte    (in_payload_byte),
    .in_message_start   (in_message_start),
    .in_payload_length  (in_payload_length),
    .in_encoding        (in_encoding),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_byte           (out_byte),
    .out_datagram_first (out_datagram_first),
    .out_datagram_last  (out_datagram_last),
    .out_byte_valid     (out_byte_valid),
    .out_status         (out_status),
    .out_run_last       (out_run_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .beats_due          (beats_due),
    .mismatches         (mismatches)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The receiver pops on a pattern indexed by rx_phase, redrawn whenever rx_phase wraps.
  // Every pattern has at least one pop in it.
  always @(negedge clk) begin
    if (rx_phase == 0) begin
      case ($urandom_range(0, 3))
        0:       rx_pattern <= '1;
        1:       rx_pattern <= 16'($urandom_range(1, 16'hFFFF));
        default: rx_pattern <= 16'($urandom_range(1, 16'hFFFF) & $urandom | 16'h0001);
      endcase
    end
    rx_phase <= rx_phase + 5'd1;
    out_pop  <= rx_steady | rx_pattern[rx_phase[3:0]];
  end

  // Watchdog: too many cycles in a row with no beat moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drives one input beat and holds it until the framer takes it. The sender
  // works in bursts with random gaps between them.
  task automatic put_beat(input logic [7:0] pb, input logic st,
                          input logic [LENGTH_BITS-1:0] len, input logic [1:0] enc);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!tx_steady && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 9);
    end
    burst_left--;
    if (gap != 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push           = 1'b1;
    in_payload_byte   = pb;
    in_message_start  = st;
    in_payload_length = len;
    in_encoding       = enc;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  // Start beat plus body beats; fewer beats than the length leaves the
  // message unfinished. Body beats carry random length and encoding.
  task automatic send_message(input logic [LENGTH_BITS-1:0] len, input logic [1:0] enc,
                              input int beats);
    int k;
    put_beat(8'($urandom), 1'b1, len, enc);
    for (k = 1; k < beats; k++)
      put_beat(8'($urandom), 1'b0, LENGTH_BITS'($urandom), 2'($urandom));
  endtask

  // Stops the sender until every owed beat has come, then lets the framer
  // finish any swallowed bytes still in flight.
  task automatic settle();
    in_push = 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = d;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [1:0] pick_encoding();
    case ($urandom_range(0, 7))
      0:       return ENC_CBOR;
      1, 2:    return ENC_UNSET;
      3, 4:    return ENC_XML;
      default: return ENC_JSON;
    endcase
  endfunction

  initial begin : stimulus
    int                     phase;
    int                     sent;
    int                     pick;
    int                     nb;
    int                     i;
    logic [LENGTH_BITS-1:0] len;
    logic [1:0]             enc;
    logic [15:0]            mss;

    rst_n             = 1'b0;
    in_push           = 1'b0;
    in_payload_byte   = '0;
    in_message_start  = 1'b0;
    in_payload_length = '0;
    in_encoding       = ENC_UNSET;
    cfg_we            = 1'b0;
    cfg_index         = CFG_PUBLISHER;
    cfg_wdata         = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, default segment size and no segmentation.
    write_reg(CFG_PUBLISHER, '0);
    write_reg(CFG_MAX_SEG, '0);
    write_reg(CFG_SEG_EN, '0);
    put_beat(8'hFF, 1'b0, '1, ENC_CBOR);                // stray byte, nothing active
    put_beat(8'h00, 1'b1, '0, ENC_XML);                 // zero-length start is ignored
    put_beat(8'h00, 1'b1, 1, ENC_UNSET);                // unset encoding sends json
    put_beat(8'hFF, 1'b1, 2, ENC_XML);
    put_beat(8'h5A, 1'b0, '0, ENC_UNSET);
    put_beat(8'hA5, 1'b1, 3, ENC_JSON);                 // abandoned by the next start
    put_beat(8'h3C, 1'b1, 1, ENC_CBOR);                 // cbor refused
    put_beat(8'h81, 1'b1, LENGTH_BITS'(DEFAULT_MSS - HDR_BASE), ENC_JSON);     // exactly fills
    put_beat(8'h7E, 1'b1, LENGTH_BITS'(DEFAULT_MSS - HDR_BASE + 1), ENC_XML);  // too large
    put_beat(8'h11, 1'b0, '0, ENC_UNSET);               // swallowed
    put_beat(8'h22, 1'b1, '1, ENC_CBOR);                // largest length, cbor
    settle();

    // Segmented message: segments of four and two payload bytes.
    write_reg(CFG_PUBLISHER, '1);
    write_reg(CFG_MAX_SEG, 20);
    write_reg(CFG_SEG_EN, 1);
    send_message(6, ENC_XML, 6);
    settle();

    // Segment size too small, then too many segments, at message start.
    write_reg(CFG_MAX_SEG, HDR_SEG);
    put_beat(8'h44, 1'b1, 5, ENC_JSON);
    settle();
    write_reg(CFG_MAX_SEG, HDR_SEG + 1);
    put_beat(8'h55, 1'b1, 40000, ENC_JSON);
    put_beat(8'h66, 1'b1, '1, ENC_UNSET);
    settle();

    // Segment size shrinks to 16 between two segments of one message.
    write_reg(CFG_MAX_SEG, 20);
    send_message(9, ENC_JSON, 4);
    settle();
    write_reg(CFG_MAX_SEG, HDR_SEG);
    put_beat(8'h77, 1'b0, '0, ENC_UNSET);
    put_beat(8'h88, 1'b0, '0, ENC_UNSET);
    settle();

    // Random traffic, a new register setting per phase.
    for (phase = 0; phase < 5; phase++) begin
      case ((phase < 2) ? phase : $urandom_range(2, 5))
        0:       mss = '0;
        1:       mss = '1;
        2, 3:    mss = 16'($urandom_range(HDR_SEG + 1, 40));
        4:       mss = 16'($urandom_range(41, 200));
        default: mss = 16'($urandom_range(1, HDR_SEG));
      endcase
      case ($urandom_range(0, 2))
        0:       write_reg(CFG_PUBLISHER, '0);
        1:       write_reg(CFG_PUBLISHER, '1);
        default: write_reg(CFG_PUBLISHER, $urandom);
      endcase
      write_reg(CFG_MAX_SEG, {16'd0, mss});
      write_reg(CFG_SEG_EN, (phase == 1) ? 0 : ($urandom_range(0, 3) != 0));
      sent = 0;
      while (sent < 25) begin
        pick = $urandom_range(0, 99);
        enc  = pick_encoding();
        if (pick < 70) begin
          // Complete message.
          len = LENGTH_BITS'($urandom_range(1, 40));
          send_message(len, enc, len);
          sent += len;
        end else if (pick < 80) begin
          // Message cut short by the next start.
          len = LENGTH_BITS'($urandom_range(2, 40));
          nb  = $urandom_range(1, len - 1);
          send_message(len, enc, nb);
          sent += nb;
        end else if (pick < 88) begin
          nb = $urandom_range(1, 3);
          for (i = 0; i < nb; i++)
            put_beat(8'($urandom), 1'b0, LENGTH_BITS'($urandom), 2'($urandom));
        end else if (pick < 92) begin
          put_beat(8'($urandom), 1'b1, '0, enc);
        end else begin
          // Length with random upper bits, only its first few bytes sent.
          nb = $urandom_range(1, 4);
          send_message(LENGTH_BITS'($urandom), enc, nb);
          sent += nb;
        end
      end
      settle();
    end

    // Both sides at full rate: a segmented message in two-byte segments.
    rx_steady = 1'b1;
    tx_steady = 1'b1;
    write_reg(CFG_MAX_SEG, HDR_SEG + 2);
    write_reg(CFG_SEG_EN, 1);
    send_message(12, ENC_XML, 12);
    rx_steady = 1'b0;
    tx_steady = 1'b0;

    settle();
    if (mismatches == 0 && beats_due == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
